// ===== rtl/core/median_filter_5x5_macros.svh =====
// Assertion shorthands for the 5x5 median filter checkers.
// Both expect clk and rst in scope.
`ifndef MEDIAN_FILTER_5X5_MACROS_SVH
`define MEDIAN_FILTER_5X5_MACROS_SVH

// Checked outside reset only
`define MF5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define MF5_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mf5_pkg.sv =====
package mf5_pkg;

  // Pixel and register widths
  localparam int PIX_W = 8;
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 13'd1920;

  // Window geometry: five rows, four of them held in the line store
  localparam int WIN      = 5;
  localparam int WIN_N    = WIN * WIN;
  localparam int ROWS     = WIN - 1;
  localparam int ROW_CW   = 3;
  localparam logic [ROW_CW-1:0] ROWS_FULL = 3'd4;
  localparam int PAD_COLS = WIN - 1;
  localparam int LINE_W   = ROWS * PIX_W;

  // Bitonic sorter over 32 lanes, 25 used, the rest padded high
  localparam int SORT_N      = 32;
  localparam int SORT_LAYERS = 15;
  localparam int LPS         = 3;   // comparator layers per register stage
  localparam int PIPE_STAGES = SORT_LAYERS / LPS;
  localparam int BUSY_W      = 3;
  localparam int MEDIAN_IDX  = WIN_N / 2;
  localparam int SORT_K [SORT_LAYERS] = '{2, 4, 4, 8, 8, 8, 16, 16, 16, 16,
                                          32, 32, 32, 32, 32};
  localparam int SORT_J [SORT_LAYERS] = '{1, 2, 1, 4, 2, 1, 8, 4, 2, 1,
                                          16, 8, 4, 2, 1};

  // Output queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int FIFO_CW    = 5;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_start;
  } in_item_t;

  typedef struct packed {
    pixel_t median;
    logic   row_end;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic row_end;
  } tag_t;

endpackage

// ===== rtl/core/mf5_out_fifo.sv =====
module mf5_out_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  mf5_pkg::out_item_t               push_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mf5_pkg::out_item_t               out_data,
  output logic [mf5_pkg::FIFO_CW-1:0]      count
);

  mf5_pkg::out_item_t              slots [mf5_pkg::FIFO_DEPTH];
  logic [mf5_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [mf5_pkg::FIFO_AW-1:0]     rd_ptr;
  logic                            pop;

  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Storage, written only when a result arrives
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/mf5_sort.sv =====
module mf5_sort (
  input  logic                                        clk,
  input  logic                                        rst,
  input  mf5_pkg::pixel_t [mf5_pkg::WIN_N-1:0]        win,
  input  mf5_pkg::tag_t                               in_tag,
  output logic                                        res_valid,
  output mf5_pkg::out_item_t                          res_item,
  output logic [mf5_pkg::BUSY_W-1:0]                  busy
);

  mf5_pkg::pixel_t lay_in  [mf5_pkg::SORT_LAYERS][mf5_pkg::SORT_N];
  mf5_pkg::pixel_t lay_out [mf5_pkg::SORT_LAYERS][mf5_pkg::SORT_N];
  mf5_pkg::pixel_t stage_q [mf5_pkg::PIPE_STAGES][mf5_pkg::SORT_N];
  mf5_pkg::tag_t   tag_q   [mf5_pkg::PIPE_STAGES];
  logic [mf5_pkg::PIPE_STAGES-1:0] stage_valid;

  genvar l, i, s;

  // Layer inputs: window (padded high) into the first, register or previous layer after
  generate
    for (i = 0; i < mf5_pkg::SORT_N; i++) begin : g_pad
      if (i < mf5_pkg::WIN_N) begin : g_pix
        assign lay_in[0][i] = win[i];
      end else begin : g_fill
        assign lay_in[0][i] = '1;
      end
    end

    for (l = 1; l < mf5_pkg::SORT_LAYERS; l++) begin : g_link
      for (i = 0; i < mf5_pkg::SORT_N; i++) begin : g_lane
        if ((l % mf5_pkg::LPS) == 0) begin : g_reg
          assign lay_in[l][i] = stage_q[l / mf5_pkg::LPS - 1][i];
        end else begin : g_comb
          assign lay_in[l][i] = lay_out[l-1][i];
        end
      end
    end

    // Compare-exchange layers of the bitonic network
    for (l = 0; l < mf5_pkg::SORT_LAYERS; l++) begin : g_layer
      localparam int K = mf5_pkg::SORT_K[l];
      localparam int J = mf5_pkg::SORT_J[l];
      for (i = 0; i < mf5_pkg::SORT_N; i++) begin : g_cx
        if ((i & J) == 0) begin : g_pair
          localparam int P = i | J;
          logic lo_gt;
          assign lo_gt = (lay_in[l][i] > lay_in[l][P]);
          if ((i & K) == 0) begin : g_up
            assign lay_out[l][i] = lo_gt ? lay_in[l][P] : lay_in[l][i];
            assign lay_out[l][P] = lo_gt ? lay_in[l][i] : lay_in[l][P];
          end else begin : g_down
            assign lay_out[l][i] = lo_gt ? lay_in[l][i] : lay_in[l][P];
            assign lay_out[l][P] = lo_gt ? lay_in[l][P] : lay_in[l][i];
          end
        end
      end
    end

    // Register after every group of layers; tags travel alongside
    for (s = 0; s < mf5_pkg::PIPE_STAGES; s++) begin : g_stage
      always_ff @(posedge clk) begin
        for (int n = 0; n < mf5_pkg::SORT_N; n++) begin
          stage_q[s][n] <= lay_out[s * mf5_pkg::LPS + mf5_pkg::LPS - 1][n];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          tag_q[s] <= '0;
        end else if (s == 0) begin
          tag_q[s] <= in_tag;
        end else begin
          tag_q[s] <= tag_q[(s == 0) ? 0 : s - 1];
        end
      end

      assign stage_valid[s] = tag_q[s].valid;
    end
  endgenerate

  assign res_valid        = tag_q[mf5_pkg::PIPE_STAGES-1].valid;
  assign res_item.median  = stage_q[mf5_pkg::PIPE_STAGES-1][mf5_pkg::MEDIAN_IDX];
  assign res_item.row_end = tag_q[mf5_pkg::PIPE_STAGES-1].row_end;
  assign busy             = mf5_pkg::BUSY_W'($countones(stage_valid));

endmodule

// ===== rtl/core/median_filter_5x5.sv =====
// Streaming 5x5 median filter. Pixels of a frame already padded by two on every side enter
// in raster order, one transaction per clock while in_ready is high; a padded row is
// row_width + 4 pixels. Once four padded rows of the frame are stored and the current row
// has reached its fifth pixel, every pixel gives one result: the exact median of its 5x5
// window, with row_end set on the last result of each output row. Throughput is one pixel
// per cycle while in_ready is high, set by the single line-store memory: each pixel reads
// its column at the edge that accepts it and writes it back in the next cycle, with
// forwarding when consecutive pixels hit the same column (frame restarts). After the read
// stage and the window register, the median comes from a 15-layer bitonic sorter
// registered every three layers. Results wait in a 16-entry queue, and in_ready drops
// only when that queue together with the results still in flight would fill. The line
// store is never cleared: its contents are only used after a frame has written four rows
// at the current row_width. row_width may be written only while no pixel is in progress;
// 0 acts as 1, values over MAX_WIDTH as MAX_WIDTH.
module median_filter_5x5 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mf5_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mf5_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mf5_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_WIDTH + mf5_pkg::PAD_COLS;
  localparam int ACW   = $clog2(DEPTH);
  localparam int CRW   = mf5_pkg::FIFO_CW + 1;

  // Last padded column for a given row width, clamped to the supported range
  function automatic logic [ACW-1:0] last_col_of(input logic [mf5_pkg::CFG_W-1:0] w);
    int eff;
    eff = int'(w);
    if (eff < 1) begin
      eff = 1;
    end
    if (eff > MAX_WIDTH) begin
      eff = MAX_WIDTH;
    end
    return ACW'(eff + mf5_pkg::PAD_COLS - 1);
  endfunction

  // Line store: four stored rows per padded column, oldest in the lowest lane
  logic [mf5_pkg::LINE_W-1:0] line_mem [DEPTH];
  logic [mf5_pkg::LINE_W-1:0] rd_data;

  logic [ACW-1:0]              last_col;
  logic [ACW-1:0]              column_count;
  logic [mf5_pkg::ROW_CW-1:0]  row_count;

  logic                        in_accept;
  logic [ACW-1:0]              col_eff;
  logic [mf5_pkg::ROW_CW-1:0]  row_eff;
  logic                        at_end;
  logic                        emit;

  logic                        s1_valid;
  logic [ACW-1:0]              s1_addr;
  mf5_pkg::pixel_t             s1_pixel;
  logic                        s1_emit;
  logic                        s1_at_end;
  logic                        fwd_hit;
  logic [mf5_pkg::LINE_W-1:0]  fwd_data;
  logic [mf5_pkg::LINE_W-1:0]  stored;
  logic [mf5_pkg::LINE_W-1:0]  wr_data;
  mf5_pkg::pixel_t [mf5_pkg::WIN-1:0] new_col;

  mf5_pkg::pixel_t [mf5_pkg::WIN-1:0][mf5_pkg::WIN-1:0] win;
  mf5_pkg::pixel_t [mf5_pkg::WIN-1:0][mf5_pkg::WIN-1:0] win_next;
  mf5_pkg::pixel_t [mf5_pkg::WIN_N-1:0]                 win_flat;
  mf5_pkg::tag_t                                        w_tag;

  logic                              res_valid;
  mf5_pkg::out_item_t                res_item;
  logic [mf5_pkg::BUSY_W-1:0]        sort_busy;
  logic [mf5_pkg::FIFO_CW-1:0]       fifo_count;
  logic [CRW-1:0]                    credit_used;

  // Configuration: the clamped last column is kept instead of the raw width
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= last_col_of(mf5_pkg::ROW_WIDTH_RESET);
    end else if (cfg_valid) begin
      last_col <= last_col_of(cfg_data);
    end
  end

  // Position of the incoming pixel; frame_start clears the counts first
  assign in_accept = in_valid && in_ready;
  assign col_eff   = in_data.frame_start ? '0 : column_count;
  assign row_eff   = in_data.frame_start ? '0 : row_count;
  assign at_end    = (col_eff >= last_col);
  assign emit      = (row_eff >= mf5_pkg::ROWS_FULL) && (col_eff >= ACW'(mf5_pkg::WIN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (at_end) begin
        column_count <= '0;
        row_count    <= (row_eff < mf5_pkg::ROWS_FULL) ? row_eff + 1'b1 : row_eff;
      end else begin
        column_count <= col_eff + 1'b1;
        row_count    <= row_eff;
      end
    end
  end

  // Line store read on acceptance, written back in the next cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= line_mem[col_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_addr] <= wr_data;
    end
  end

  // Read stage; catch a write-back to the same column at the read edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr   <= col_eff;
      s1_pixel  <= in_data.pixel;
      s1_emit   <= emit;
      s1_at_end <= at_end;
      fwd_hit   <= s1_valid && (s1_addr == col_eff);
      fwd_data  <= wr_data;
    end
  end

  // New window column: four stored rows, oldest first, then the pixel
  assign stored = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    for (int r = 0; r < mf5_pkg::ROWS; r++) begin
      new_col[r] = stored[r * mf5_pkg::PIX_W +: mf5_pkg::PIX_W];
    end
    new_col[mf5_pkg::WIN-1] = s1_pixel;
    for (int r = 0; r < mf5_pkg::ROWS; r++) begin
      wr_data[r * mf5_pkg::PIX_W +: mf5_pkg::PIX_W] = new_col[r + 1];
    end
  end

  // Window shifts left by one column per pixel
  always_comb begin
    for (int r = 0; r < mf5_pkg::WIN; r++) begin
      for (int x = 0; x < mf5_pkg::WIN - 1; x++) begin
        win_next[r][x] = win[r][x + 1];
      end
      win_next[r][mf5_pkg::WIN-1] = new_col[r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_tag <= '0;
    end else begin
      w_tag.valid   <= s1_valid && s1_emit;
      w_tag.row_end <= s1_at_end;
    end
  end

  always_comb begin
    for (int r = 0; r < mf5_pkg::WIN; r++) begin
      for (int x = 0; x < mf5_pkg::WIN; x++) begin
        win_flat[r * mf5_pkg::WIN + x] = win[r][x];
      end
    end
  end

  // Median network
  mf5_sort u_sort (
    .clk       (clk),
    .rst       (rst),
    .win       (win_flat),
    .in_tag    (w_tag),
    .res_valid (res_valid),
    .res_item  (res_item),
    .busy      (sort_busy)
  );

  // Result queue
  mf5_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_item (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  // Accept only while every result in flight is sure of a queue slot
  assign credit_used = CRW'(fifo_count) + CRW'(sort_busy) + CRW'(w_tag.valid)
                     + CRW'(s1_valid && s1_emit);
  assign in_ready    = (credit_used < CRW'(mf5_pkg::FIFO_DEPTH));

endmodule

// ===== rtl/core/median_filter_5x5_checker.sv =====
`include "median_filter_5x5_macros.svh"

module median_filter_5x5_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input mf5_pkg::out_item_t            out_data
);

  // A stalled result transaction keeps its value
  `MF5_ASSERT(a_out_hold,
              out_valid && !out_ready |=> out_valid && $stable(out_data),
              "result changed while stalled")

  // A result leaving an empty queue comes from an earlier accepted pixel
  `MF5_ASSERT(a_latency,
              $rose(out_valid) |-> $past(in_valid && in_ready, 8),
              "result without a matching pixel")

  // With the queue empty there is always room for another pixel
  `MF5_ASSERT(a_room, !out_valid |-> in_ready, "input stalled with an empty queue")

  // Reset leaves no result pending and the input open
  `MF5_ASSERT_ALWAYS(a_reset, $past(rst) |-> !out_valid && in_ready, "state left after reset")

endmodule

bind median_filter_5x5 median_filter_5x5_props u_checker (.*);
